>>> hdl/sampson_squared_error_core_macros.svh
// Assertion helpers shared by the pipeline modules
`ifndef SAMPSON_SQUARED_ERROR_CORE_MACROS_SVH
`define SAMPSON_SQUARED_ERROR_CORE_MACROS_SVH

`define SSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/sse_pkg.sv
`timescale 1ns / 1ps
package sse_pkg;
   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int COEF_FRAC_BITS_DEF  = 20;
   localparam int COORD_W   = 32;
   localparam int COEF_W    = 21;
   localparam int ROW_W     = 63;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_W     = 48;
   localparam int OUT_FRAC  = 16;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_TWO  = 2'd2;
   // line and column terms: |coef*coord| <= 2^51, three of them fit 54 bits
   localparam int LINE_W    = 56;
   localparam int NUM_W     = 90;
   localparam int SQ_W      = 112;
   localparam int DEN_W     = 115;
   localparam int NSQ_W     = 180;

   typedef struct packed {
      logic valid;
      logic degen;
      logic sat;
   } flag_type;
endpackage

>>> hdl/sse_front.sv
`timescale 1ns / 1ps
module sse_front #(
   parameter int COORD_FRAC_BITS = sse_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [sse_pkg::COORD_W-1:0] x1,
   input  logic signed [sse_pkg::COORD_W-1:0] y1,
   input  logic signed [sse_pkg::COORD_W-1:0] x2,
   input  logic signed [sse_pkg::COORD_W-1:0] y2,
   input  logic [sse_pkg::ROW_W-1:0]          row0,
   input  logic [sse_pkg::ROW_W-1:0]          row1,
   input  logic [sse_pkg::ROW_W-1:0]          row2,
   output logic                              out_valid,
   output logic signed [sse_pkg::NUM_W-1:0]   num,
   output logic [sse_pkg::DEN_W-1:0]          den
);
   localparam int LW  = sse_pkg::LINE_W;
   localparam int PW  = 53;
   // line and column terms are split in two halves for the products
   localparam int HW  = LW / 2;
   localparam int NPW = 62;
   localparam int SPW = 58;
   logic signed [sse_pkg::COEF_W-1:0] e [3][3];
   logic signed [PW-1:0] pl_in [3][3], pc_in [2][3];
   logic signed [PW-1:0] pl_ff [3][3], pc_ff [2][3];
   logic signed [sse_pkg::COORD_W-1:0] x2a_ff, y2a_ff;
   logic signed [LW-1:0] l_ff [3], c_ff [2];
   logic signed [sse_pkg::COORD_W-1:0] x2b_ff, y2b_ff;
   logic signed [LW-1:0] sv [4];
   logic signed [HW-1:0] svh [4];
   logic [HW-1:0] svl [4];
   logic signed [NPW-1:0] pnh_in [2], pnl_in [2], pnh_ff [2], pnl_ff [2];
   logic signed [SPW-1:0] shh_in [4], shl_in [4], shh_ff [4], shl_ff [4];
   logic [2*HW-1:0] sll_in [4], sll_ff [4];
   logic signed [LW-1:0] l2_ff;
   logic signed [sse_pkg::NUM_W-1:0] num_ff;
   logic [sse_pkg::SQ_W-1:0] sq_ff [4];
   logic [3:0] v_ff;
   logic signed [PW-1:0] one;

   assign one = PW'(1) <<< COORD_FRAC_BITS;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         e[0][c] = row0[21*c +: 21];
         e[1][c] = row1[21*c +: 21];
         e[2][c] = row2[21*c +: 21];
      end
      for (int r = 0; r < 3; r++) begin
         pl_in[r][0] = PW'(e[r][0]) * PW'(x1);
         pl_in[r][1] = PW'(e[r][1]) * PW'(y1);
         pl_in[r][2] = PW'(e[r][2]) * one;
      end
      for (int c = 0; c < 2; c++) begin
         pc_in[c][0] = PW'(e[0][c]) * PW'(x2);
         pc_in[c][1] = PW'(e[1][c]) * PW'(y2);
         pc_in[c][2] = PW'(e[2][c]) * one;
      end
      sv[0] = c_ff[0];
      sv[1] = c_ff[1];
      sv[2] = l_ff[0];
      sv[3] = l_ff[1];
      for (int k = 0; k < 4; k++) begin
         svh[k] = sv[k][LW-1:HW];
         svl[k] = sv[k][HW-1:0];
         shh_in[k] = SPW'(svh[k]) * SPW'(svh[k]);
         shl_in[k] = SPW'(svh[k]) * SPW'($signed({1'b0, svl[k]}));
         sll_in[k] = (2*HW)'(svl[k]) * (2*HW)'(svl[k]);
      end
      pnh_in[0] = NPW'(svh[2]) * NPW'(x2b_ff);
      pnl_in[0] = NPW'($signed({1'b0, svl[2]})) * NPW'(x2b_ff);
      pnh_in[1] = NPW'(svh[3]) * NPW'(y2b_ff);
      pnl_in[1] = NPW'($signed({1'b0, svl[3]})) * NPW'(y2b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff  <= pl_in;
         pc_ff  <= pc_in;
         x2a_ff <= x2;
         y2a_ff <= y2;
         for (int r = 0; r < 3; r++)
            l_ff[r] <= LW'(pl_ff[r][0]) + LW'(pl_ff[r][1]) + LW'(pl_ff[r][2]);
         for (int c = 0; c < 2; c++)
            c_ff[c] <= LW'(pc_ff[c][0]) + LW'(pc_ff[c][1]) + LW'(pc_ff[c][2]);
         x2b_ff <= x2a_ff;
         y2b_ff <= y2a_ff;
         pnh_ff <= pnh_in;
         pnl_ff <= pnl_in;
         shh_ff <= shh_in;
         shl_ff <= shl_in;
         sll_ff <= sll_in;
         l2_ff  <= l_ff[2];
         num_ff <= (sse_pkg::NUM_W'(pnh_ff[0]) <<< HW) + sse_pkg::NUM_W'(pnl_ff[0])
                 + (sse_pkg::NUM_W'(pnh_ff[1]) <<< HW) + sse_pkg::NUM_W'(pnl_ff[1])
                 + (sse_pkg::NUM_W'(l2_ff) <<< COORD_FRAC_BITS);
         // a^2 = hi^2 << 2H + 2 hi lo << H + lo^2
         for (int k = 0; k < 4; k++)
            sq_ff[k] <= (sse_pkg::SQ_W'(shh_ff[k]) <<< (2*HW))
                      + (sse_pkg::SQ_W'(shl_ff[k]) <<< (HW+1))
                      + sse_pkg::SQ_W'($signed({1'b0, sll_ff[k]}));
      end
   end

   assign out_valid = v_ff[3];
   assign num = num_ff;
   assign den = sse_pkg::DEN_W'(sq_ff[0]) + sse_pkg::DEN_W'(sq_ff[1])
              + sse_pkg::DEN_W'(sq_ff[2]) + sse_pkg::DEN_W'(sq_ff[3]);
endmodule

>>> hdl/sse_divider.sv
`timescale 1ns / 1ps
module sse_divider #(
   parameter int COORD_FRAC_BITS = sse_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic signed [sse_pkg::NUM_W-1:0] num,
   input  logic [sse_pkg::DEN_W-1:0]        den,
   output sse_pkg::flag_type               out_flags,
   output logic [sse_pkg::OUT_W-1:0]        out_q
);
   `include "sampson_squared_error_core_macros.svh"
   localparam int QW  = sse_pkg::OUT_W;
   localparam int NW  = sse_pkg::NSQ_W + sse_pkg::OUT_FRAC;
   localparam int DW  = sse_pkg::DEN_W + 2*COORD_FRAC_BITS;
   localparam int RW  = DW + QW + 1;
   // numerator magnitude squared from three limbs
   localparam int MW  = sse_pkg::NUM_W / 3;
   localparam int MPW = 2*MW;

   logic [sse_pkg::NUM_W-1:0] mag_ff;
   logic [sse_pkg::DEN_W-1:0] den_a_ff, den_b_ff;
   logic va_ff, vb_ff, vc_ff;
   logic [MW-1:0] m [3];
   logic [MPW-1:0] mp_in [6], mp_ff [6];
   logic [sse_pkg::NSQ_W-1:0] nsq;
   logic [NW-1:0] nn_ff;
   logic [DW-1:0] dd_ff;
   logic [QW:0] sv_ff, dg_ff, st_ff;
   logic [NW-1:0] rem_ff [QW];
   logic [NW-1:0] rem_in [QW-1];
   logic [DW-1:0] dv_ff [QW];
   logic [QW-1:0] q_ff [QW+1];
   logic [DW:0] win [QW];
   logic [QW-1:0] take;
   logic [RW-1:0] lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         sv_ff <= '0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         sv_ff <= {sv_ff[QW-1:0], vc_ff};
      end
   end

   always_comb begin
      m[0] = mag_ff[0 +: MW];
      m[1] = mag_ff[MW +: MW];
      m[2] = mag_ff[2*MW +: MW];
      mp_in[0] = MPW'(m[0]) * MPW'(m[0]);
      mp_in[1] = MPW'(m[0]) * MPW'(m[1]);
      mp_in[2] = MPW'(m[0]) * MPW'(m[2]);
      mp_in[3] = MPW'(m[1]) * MPW'(m[1]);
      mp_in[4] = MPW'(m[1]) * MPW'(m[2]);
      mp_in[5] = MPW'(m[2]) * MPW'(m[2]);
   end

   assign nsq = sse_pkg::NSQ_W'(mp_ff[0])
              + (sse_pkg::NSQ_W'(mp_ff[1]) << (MW+1))
              + (sse_pkg::NSQ_W'(mp_ff[2]) << (2*MW+1))
              + (sse_pkg::NSQ_W'(mp_ff[3]) << (2*MW))
              + (sse_pkg::NSQ_W'(mp_ff[4]) << (3*MW+1))
              + (sse_pkg::NSQ_W'(mp_ff[5]) << (4*MW));

   assign lim = RW'(dd_ff) << QW;

   // remainder stays below dv << (bit+1), so only a window needs comparing
   always_comb begin
      for (int j = 0; j < QW; j++) begin
         win[j]  = rem_ff[j][QW-1-j +: DW+1];
         take[j] = (win[j] >= {1'b0, dv_ff[j]});
      end
      for (int j = 0; j < QW-1; j++) begin
         rem_in[j] = rem_ff[j];
         if (take[j])
            rem_in[j][QW-1-j +: DW+1] = win[j] - {1'b0, dv_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff   <= num[sse_pkg::NUM_W-1] ? -num : num;
         den_a_ff <= den;
         mp_ff    <= mp_in;
         den_b_ff <= den_a_ff;
         nn_ff    <= {nsq, {sse_pkg::OUT_FRAC{1'b0}}};
         dd_ff    <= DW'(den_b_ff) << (2*COORD_FRAC_BITS);
         dg_ff    <= {dg_ff[QW-1:0], (dd_ff == '0)};
         st_ff    <= {st_ff[QW-1:0], (dd_ff != '0) && (RW'(nn_ff) >= lim)};
         rem_ff[0] <= nn_ff;
         dv_ff[0]  <= dd_ff;
         q_ff[0]   <= '0;
         for (int j = 0; j < QW-1; j++) begin
            rem_ff[j+1] <= rem_in[j];
            dv_ff[j+1]  <= dv_ff[j];
         end
         for (int j = 0; j < QW; j++)
            q_ff[j+1] <= q_ff[j] | (QW'(take[j]) << (QW-1-j));
      end
   end

   assign out_flags = '{valid: sv_ff[QW], degen: dg_ff[QW], sat: st_ff[QW]};
   assign out_q = (dg_ff[QW] || st_ff[QW]) ? '1 : q_ff[QW];

   `SSE_ASSERT_IMPL(a_flags_excl, clock, reset, out_flags.valid, !(out_flags.degen && out_flags.sat))
   `SSE_ASSERT_NEXT(a_hold, clock, reset, !adv, $stable(out_q))
   `SSE_ASSERT_IMPL(a_degen_ones, clock, reset, out_flags.valid && out_flags.degen, out_q == '1)
endmodule

>>> hdl/sampson_squared_error_core.sv
`timescale 1ns / 1ps
// Squared Sampson epipolar error, one correspondence per request.
// Channels: req_* carries the two points (signed Q16.16) with req_valid /
// req_stall; rsp_* returns residual (unsigned Q32.16), saturated and
// degenerate with rsp_valid / rsp_stall. The matrix rows are written through
// csr_valid / csr_ready / csr_index / csr_data and should only change while idle.
// Throughput: one request per cycle unless a held response stalls the pipe.
// Stages: 4 front stages, 3 squaring stages, a range-check stage and 48
// quotient stages; the divider gives one quotient bit per stage.
// Pipeline is a single enable: while rsp_valid is high and rsp_stall is high
// every stage holds and req_stall is raised, so nothing is lost or repeated.
// Bubbles in the pipe still advance when the output is empty.
// Reset (synchronous) clears the matrix rows to zero and empties the pipe.
module sampson_squared_error_core #(
   parameter int COORD_FRAC_BITS = sse_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [sse_pkg::COORD_W-1:0] req_first_x,
   input  logic signed [sse_pkg::COORD_W-1:0] req_first_y,
   input  logic signed [sse_pkg::COORD_W-1:0] req_second_x,
   input  logic signed [sse_pkg::COORD_W-1:0] req_second_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sse_pkg::OUT_W-1:0]          rsp_residual,
   output logic                              rsp_saturated,
   output logic                              rsp_degenerate,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sse_pkg::ROW_W-1:0]          csr_data
);
   `include "sampson_squared_error_core_macros.svh"
   logic [sse_pkg::ROW_W-1:0] row0_ff, row1_ff, row2_ff;
   logic adv, fv;
   logic signed [sse_pkg::NUM_W-1:0] num;
   logic [sse_pkg::DEN_W-1:0] den;
   sse_pkg::flag_type flags;
   logic [sse_pkg::OUT_W-1:0] q;

   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= '0;
         row1_ff <= '0;
         row2_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sse_pkg::REG_ROW_ZERO: row0_ff <= csr_data;
            sse_pkg::REG_ROW_ONE:  row1_ff <= csr_data;
            sse_pkg::REG_ROW_TWO:  row2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   sse_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock, .reset, .adv, .in_valid(req_valid),
      .x1(req_first_x), .y1(req_first_y), .x2(req_second_x), .y2(req_second_y),
      .row0(row0_ff), .row1(row1_ff), .row2(row2_ff),
      .out_valid(fv), .num, .den
   );

   sse_divider #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div (
      .clock, .reset, .adv, .in_valid(fv), .num, .den,
      .out_flags(flags), .out_q(q)
   );

   assign rsp_valid      = flags.valid;
   assign rsp_residual   = q;
   assign rsp_saturated  = flags.sat;
   assign rsp_degenerate = flags.degen;

   `SSE_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SSE_ASSERT_IMPL(a_stall_link, clock, reset, rsp_valid && rsp_stall, req_stall)
   `SSE_ASSERT_IMPL(a_sat_ones, clock, reset, rsp_valid && rsp_saturated, rsp_residual == '1)
endmodule

>>> test/sampson_squared_error_core_tb.sv
`timescale 1ns / 1ps
module sampson_squared_error_core_tb;
   localparam logic [sse_pkg::CSR_IDX_W-1:0] REG_NONE = 2'd3;

   typedef struct {
      logic [sse_pkg::OUT_W-1:0] residual;
      logic                      saturated;
      logic                      degenerate;
   } sampson_result_type;

   class sampson_scoreboard;
      sampson_result_type pending[$];
      int errors = 0;

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void note_request(sampson_result_type r);
         pending.push_back(r);
      endfunction

      task check_result(sampson_result_type got);
         sampson_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got.residual));
            return;
         end
         want = pending.pop_front();
         if (got.residual !== want.residual)
            report($sformatf("residual %h want %h", got.residual, want.residual));
         if (got.saturated !== want.saturated)
            report($sformatf("saturated %b want %b", got.saturated, want.saturated));
         if (got.degenerate !== want.degenerate)
            report($sformatf("degenerate %b want %b", got.degenerate, want.degenerate));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [sse_pkg::COORD_W-1:0] req_first_x = 0, req_first_y = 0;
   logic signed [sse_pkg::COORD_W-1:0] req_second_x = 0, req_second_y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [sse_pkg::OUT_W-1:0] rsp_residual;
   logic rsp_saturated, rsp_degenerate;
   logic csr_valid = 0;
   logic csr_ready;
   logic [sse_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [sse_pkg::ROW_W-1:0] csr_data = 0;

   sampson_squared_error_core DUT (.*);

   always #1 clock = ~clock;

   sampson_scoreboard sb = new();
   logic [sse_pkg::ROW_W-1:0] matrix_rows[3] = '{default: '0};
   int send_idle_pct = 0, recv_idle_pct = 0;
   bit long_hold = 0;
   int cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver back-pressure, with one long hold-off on request
   int hold_left = 0;
   always @(posedge clock) begin
      if (long_hold && hold_left == 0) begin
         hold_left = 300;
         long_hold = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      sampson_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.residual = rsp_residual;
         got.saturated = rsp_saturated;
         got.degenerate = rsp_degenerate;
         sb.check_result(got);
      end
   end

   function automatic sampson_result_type sampson_predict(
      logic signed [31:0] ax1, ay1, ax2, ay2);
      logic signed [255:0] e[3][3];
      logic signed [255:0] l[3];
      logic signed [255:0] x1, y1, x2, y2, one, c0, c1, num, nsq;
      logic [319:0] d, nn, dd, lim;
      sampson_result_type r;
      x1 = ax1; y1 = ay1; x2 = ax2; y2 = ay2;
      one = 256'sd65536;
      for (int i = 0; i < 3; i++)
         for (int c = 0; c < 3; c++)
            e[i][c] = $signed(matrix_rows[i][21*c +: 21]);
      for (int i = 0; i < 3; i++)
         l[i] = e[i][0] * x1 + e[i][1] * y1 + e[i][2] * one;
      c0 = x2 * e[0][0] + y2 * e[1][0] + one * e[2][0];
      c1 = x2 * e[0][1] + y2 * e[1][1] + one * e[2][1];
      num = x2 * l[0] + y2 * l[1] + one * l[2];
      d = {64'b0, 256'(c0 * c0)} + {64'b0, 256'(c1 * c1)}
        + {64'b0, 256'(l[0] * l[0])} + {64'b0, 256'(l[1] * l[1])};
      r.residual = '1; r.saturated = 0; r.degenerate = 0;
      if (d == 0) begin
         r.degenerate = 1;
         return r;
      end
      nsq = num * num;
      nn = {64'b0, 256'(nsq)} << 16;
      dd = d << 32;
      lim = dd << 48;
      if (nn >= lim) begin
         r.saturated = 1;
         return r;
      end
      r.residual = sse_pkg::OUT_W'(nn / dd);
      return r;
   endfunction

   task automatic write_row(logic [sse_pkg::CSR_IDX_W-1:0] idx,
                            logic [sse_pkg::ROW_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == sse_pkg::REG_ROW_ZERO) matrix_rows[0] = val;
      else if (idx == sse_pkg::REG_ROW_ONE) matrix_rows[1] = val;
      else if (idx == sse_pkg::REG_ROW_TWO) matrix_rows[2] = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(logic [31:0] ax1, ay1, ax2, ay2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_first_x <= ax1; req_first_y <= ay1;
      req_second_x <= ax2; req_second_y <= ay2;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(sampson_predict(ax1, ay1, ax2, ay2));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152)) - 1048576);
         default: return 32'($signed($urandom_range(1310720)) - 655360);
      endcase
   endfunction

   function automatic logic [20:0] rand_coef();
      case ($urandom_range(4))
         0: return 21'h0fffff;
         1: return 21'h100000;
         2: return 21'($signed($urandom_range(4096)) - 2048);
         default: return 21'($urandom);
      endcase
   endfunction

   task automatic random_matrix();
      for (int i = 0; i < 3; i++)
         write_row(sse_pkg::CSR_IDX_W'(i), {rand_coef(), rand_coef(), rand_coef()});
   endtask

   task automatic random_batch(int n);
      for (int k = 0; k < n; k++) begin
         if (k % 50 == 49) begin
            drain_pipe();
            random_matrix();
         end
         send_request(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 18; recv_idle_pct = 78;

      // zero matrix: every request is degenerate
      send_request(32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffff0000);
      send_request(0, 0, 0, 0);
      drain_pipe();

      // all-ones rows: every entry is -1 lsb
      write_row(sse_pkg::REG_ROW_ZERO, '1);
      write_row(sse_pkg::REG_ROW_ONE, '1);
      write_row(sse_pkg::REG_ROW_TWO, '1);
      write_row(REG_NONE, 63'h123456789abcdef);
      send_request(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_request(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_request(32'h00010000, 0, 0, 32'h00010000);
      send_request(32'hffffffff, 32'h00000001, 32'h55555555, 32'haaaaaaaa);
      drain_pipe();

      // most positive and most negative entries
      write_row(sse_pkg::REG_ROW_ZERO, {3{21'h0fffff}});
      write_row(sse_pkg::REG_ROW_ONE, {3{21'h100000}});
      write_row(sse_pkg::REG_ROW_TWO, {21'h0fffff, 21'h100000, 21'h0fffff});
      send_request(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_request(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_request(0, 0, 0, 0);
      send_request(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
      drain_pipe();

      // cross-product style matrix of a pure x translation: small residuals
      write_row(sse_pkg::REG_ROW_ZERO, 63'd0);
      write_row(sse_pkg::REG_ROW_ONE, {21'h0fffff, 21'd0, 21'd0});
      write_row(sse_pkg::REG_ROW_TWO, {21'd0, 21'h100000 + 21'd1, 21'd0});
      send_request(32'h00020000, 32'h00030000, 32'h00020000, 32'h00030000);
      send_request(32'h00020000, 32'h00030000, 32'h00025000, 32'h00031000);
      send_request(32'hfff00000, 32'h00100000, 32'h00100000, 32'hfff00000);
      send_request(0, 0, 0, 32'h00008000);
      // only E(2,2) set: l0, l1 and both columns vanish
      drain_pipe();
      write_row(sse_pkg::REG_ROW_ONE, 63'd0);
      write_row(sse_pkg::REG_ROW_TWO, {21'h0fffff, 21'd0, 21'd0});
      send_request(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321);
      drain_pipe();

      random_matrix();
      random_batch(200);
      drain_pipe();

      send_idle_pct = 78; recv_idle_pct = 18;
      random_matrix();
      random_batch(200);
      drain_pipe();

      send_idle_pct = 0; recv_idle_pct = 0;
      random_matrix();
      // long hold-off: more requests than the pipe holds, so the input stalls
      long_hold = 1;
      repeat (100) send_request(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      drain_pipe();
      random_matrix();
      random_batch(100);
      drain_pipe();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
